FILE: hw/rtl/mms_pkg.sv
package mms_pkg;

    // default configuration
    localparam int MAX_CHAINS_DEF  = 16;
    localparam int DEPTH_LIMIT_DEF = 8;

    // field widths
    localparam int ID_W    = 16;
    localparam int SLOT_W  = 7;
    localparam int DEPTH_W = 3;
    localparam int CNT_W   = 7;
    localparam int NUM_W   = 6;
    localparam int SIZE_W  = 8;

    // hash constants
    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;

    // one loaded chain set, handed from front to back
    typedef struct packed {
        logic               bank;
        logic [CNT_W-1:0]   count;
        logic [DEPTH_W-1:0] start_depth;
        logic               no_trial;
    } job_t;

    // chain id write from front into the id store
    typedef struct packed {
        logic            en;
        logic            bank;
        logic [NUM_W-1:0] idx;
        logic [ID_W-1:0]  id;
    } id_wr_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CHECK,
        BK_EMIT,
        BK_FAIL
    } back_state_t;

    // low seven bits of the double lcg step; only low bits of the operands matter
    function automatic logic [SLOT_W-1:0] leaf_slot(
        input logic [SLOT_W-1:0] nonce,
        input logic [ID_W-1:0]   id
    );
        logic [2*SLOT_W-1:0] prod;
        logic [SLOT_W-1:0]   r;
        prod = {{SLOT_W{1'b0}}, nonce} * {{SLOT_W{1'b0}}, LCG_MUL[SLOT_W-1:0]};
        r    = prod[SLOT_W-1:0] + LCG_ADD[SLOT_W-1:0];
        r    = r + id[SLOT_W-1:0];
        prod = {{SLOT_W{1'b0}}, r} * {{SLOT_W{1'b0}}, LCG_MUL[SLOT_W-1:0]};
        return prod[SLOT_W-1:0] + LCG_ADD[SLOT_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/mms_front.sv
module mms_front #(
    parameter int MAX_CHAINS  = mms_pkg::MAX_CHAINS_DEF,
    parameter int DEPTH_LIMIT = mms_pkg::DEPTH_LIMIT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [mms_pkg::ID_W-1:0]   s_chain_id,
    input  logic                       s_last_chain,
    output mms_pkg::id_wr_t            id_wr,
    output logic                       job_push,
    output mms_pkg::job_t              job,
    input  logic                       job_done
);

    localparam int CW = $clog2(MAX_CHAINS + 1);

    logic [CW-1:0]               count_reg, count_next;
    logic                        bank_reg, bank_next;
    logic [1:0]                  outst_reg, outst_next;
    logic                        accept;
    logic                        room;
    logic [CW-1:0]               total;
    logic [mms_pkg::DEPTH_W-1:0] start_d;

    // two id banks: stall while both hold sets still owned by the back
    assign s_ready = (outst_reg != 2'd2);
    assign accept  = s_valid && s_ready;
    assign room    = (count_reg < CW'(MAX_CHAINS));
    assign total   = room ? count_reg + CW'(1) : count_reg;

    // start depth: smallest depth whose leaf count covers the set, at most 7
    always_comb begin
        start_d = '0;
        for (int d = 0; d < 7; d++) begin
            if ((32'd1 << d) < 32'(total)) begin
                start_d = mms_pkg::DEPTH_W'(d + 1);
            end
        end
    end

    // id store write and request classification
    always_comb begin
        id_wr.en         = accept && room;
        id_wr.bank       = bank_reg;
        id_wr.idx        = mms_pkg::NUM_W'(count_reg);
        id_wr.id         = s_chain_id;
        job_push         = accept && s_last_chain;
        job.bank         = bank_reg;
        job.count        = mms_pkg::CNT_W'(total);
        job.start_depth  = start_d;
        job.no_trial     = ({1'b0, start_d} >= 4'(DEPTH_LIMIT));
    end

    // next state
    always_comb begin
        count_next = count_reg;
        bank_next  = bank_reg;
        if (accept) begin
            if (s_last_chain) begin
                count_next = '0;
                bank_next  = !bank_reg;
            end else if (room) begin
                count_next = count_reg + CW'(1);
            end
        end
        outst_next = outst_reg + {1'b0, job_push} - {1'b0, job_done};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            bank_reg  <= 1'b0;
            outst_reg <= '0;
        end else begin
            count_reg <= count_next;
            bank_reg  <= bank_next;
            outst_reg <= outst_next;
        end
    end

    // sets in flight never exceed the two banks
    a_outst_max: assert property (@(posedge aclk) disable iff (!aresetn)
        outst_reg != 2'd3)
        else $error("front: more sets in flight than banks");

endmodule

FILE: hw/rtl/mms_queue.sv
module mms_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mms_pkg::job_t push_job,
    input  logic          pop,
    output mms_pkg::job_t pop_job,
    output logic          empty
);

    mms_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    fill_reg;
    logic          full;

    assign empty   = (fill_reg == 2'd0);
    assign full    = (fill_reg == 2'd2);
    assign pop_job = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue: request pushed while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue: pop while empty");

endmodule

FILE: hw/rtl/mms_back.sv
module mms_back #(
    parameter int MAX_CHAINS  = mms_pkg::MAX_CHAINS_DEF,
    parameter int DEPTH_LIMIT = mms_pkg::DEPTH_LIMIT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mms_pkg::id_wr_t               id_wr,
    input  logic                          job_empty,
    input  mms_pkg::job_t                 job_in,
    output logic                          job_pop,
    output logic                          job_done,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mms_pkg::NUM_W-1:0]     m_chain_number,
    output logic [mms_pkg::SLOT_W-1:0]    m_chain_slot,
    output logic [mms_pkg::SLOT_W-1:0]    m_search_nonce,
    output logic [mms_pkg::SIZE_W-1:0]    m_tree_size,
    output logic                          m_found,
    output logic                          m_last_result
);

    localparam int IW    = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS) : 1;
    localparam int AW    = IW + 1;
    localparam int MEM_D = 2 ** AW;
    localparam int NSLOT = 2 ** mms_pkg::SLOT_W;

    mms_pkg::back_state_t        state_reg, state_next;
    mms_pkg::job_t               job_reg, job_next;
    logic [mms_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    logic [mms_pkg::SLOT_W-1:0]  nonce_reg, nonce_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic [NSLOT-1:0]            taken_reg, taken_next;

    logic [mms_pkg::ID_W-1:0]    id_mem [MEM_D];
    logic [mms_pkg::ID_W-1:0]    rd_data_reg;
    logic [AW-1:0]               rd_addr;

    logic                        m_valid_reg, m_valid_next;
    logic [mms_pkg::NUM_W-1:0]   m_number_reg, m_number_next;
    logic [mms_pkg::SLOT_W-1:0]  m_slot_reg, m_slot_next;
    logic [mms_pkg::SLOT_W-1:0]  m_nonce_reg, m_nonce_next;
    logic [mms_pkg::SIZE_W-1:0]  m_size_reg, m_size_next;
    logic                        m_found_reg, m_found_next;
    logic                        m_last_reg, m_last_next;

    logic [mms_pkg::SLOT_W-1:0]  depth_mask;
    logic [mms_pkg::SLOT_W-1:0]  slot;
    logic                        hit;
    logic                        last_idx;
    logic                        last_nonce;
    logic [3:0]                  depth_up;
    logic                        out_free;

    // slot of the chain whose id is in the read register
    assign depth_mask = mms_pkg::SLOT_W'((8'd1 << depth_reg) - 8'd1);
    assign slot       = mms_pkg::leaf_slot(nonce_reg, rd_data_reg) & depth_mask;
    assign hit        = taken_reg[slot];
    assign last_idx   = (mms_pkg::CNT_W'(idx_reg) == job_reg.count - mms_pkg::CNT_W'(1));
    assign last_nonce = (nonce_reg == depth_mask);
    assign depth_up   = {1'b0, depth_reg} + 4'd1;
    assign out_free   = !m_valid_reg || m_ready;
    assign rd_addr    = {job_next.bank, idx_next};

    // id store: front writes one bank, search reads the other
    always_ff @(posedge aclk) begin
        if (id_wr.en) begin
            id_mem[{id_wr.bank, id_wr.idx[IW-1:0]}] <= id_wr.id;
        end
        rd_data_reg <= id_mem[rd_addr];
    end

    // search and result sequencer
    always_comb begin
        state_next    = state_reg;
        job_next      = job_reg;
        depth_next    = depth_reg;
        nonce_next    = nonce_reg;
        idx_next      = idx_reg;
        taken_next    = taken_reg;
        job_pop       = 1'b0;
        job_done      = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_number_next = m_number_reg;
        m_slot_next   = m_slot_reg;
        m_nonce_next  = m_nonce_reg;
        m_size_next   = m_size_reg;
        m_found_next  = m_found_reg;
        m_last_next   = m_last_reg;
        case (state_reg)
            mms_pkg::BK_IDLE: begin
                if (!job_empty) begin
                    job_pop    = 1'b1;
                    job_next   = job_in;
                    idx_next   = '0;
                    nonce_next = '0;
                    depth_next = job_in.start_depth;
                    taken_next = '0;
                    state_next = job_in.no_trial ? mms_pkg::BK_FAIL : mms_pkg::BK_CHECK;
                end
            end
            mms_pkg::BK_CHECK: begin
                if (hit) begin
                    // collision: fresh trial with the next nonce or depth, or failure once both run out
                    taken_next = '0;
                    idx_next   = '0;
                    if (!last_nonce) begin
                        nonce_next = nonce_reg + mms_pkg::SLOT_W'(1);
                    end else if (depth_up < 4'(DEPTH_LIMIT) && depth_up < 4'd8) begin
                        depth_next = depth_up[mms_pkg::DEPTH_W-1:0];
                        nonce_next = '0;
                    end else begin
                        state_next = mms_pkg::BK_FAIL;
                    end
                end else begin
                    taken_next[slot] = 1'b1;
                    if (last_idx) begin
                        idx_next   = '0;
                        state_next = mms_pkg::BK_EMIT;
                    end else begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            mms_pkg::BK_EMIT: begin
                // slots recomputed from the winning nonce, one chain per cycle while the output is free
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_number_next = mms_pkg::NUM_W'(idx_reg);
                    m_slot_next   = slot;
                    m_nonce_next  = nonce_reg;
                    m_size_next   = 8'd1 << depth_reg;
                    m_found_next  = 1'b1;
                    m_last_next   = last_idx;
                    if (last_idx) begin
                        job_done   = 1'b1;
                        state_next = mms_pkg::BK_IDLE;
                    end else begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            mms_pkg::BK_FAIL: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_number_next = '0;
                    m_slot_next   = '0;
                    m_nonce_next  = '0;
                    m_size_next   = '0;
                    m_found_next  = 1'b0;
                    m_last_next   = 1'b1;
                    job_done      = 1'b1;
                    state_next    = mms_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = mms_pkg::BK_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mms_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
            taken_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            taken_reg   <= taken_next;
        end
    end

    // search registers and result payload
    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        depth_reg    <= depth_next;
        nonce_reg    <= nonce_next;
        idx_reg      <= idx_next;
        m_number_reg <= m_number_next;
        m_slot_reg   <= m_slot_next;
        m_nonce_reg  <= m_nonce_next;
        m_size_reg   <= m_size_next;
        m_found_reg  <= m_found_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_chain_number = m_number_reg;
    assign m_chain_slot   = m_slot_reg;
    assign m_search_nonce = m_nonce_reg;
    assign m_tree_size    = m_size_reg;
    assign m_found        = m_found_reg;
    assign m_last_result  = m_last_reg;

    a_idx_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mms_pkg::BK_CHECK || state_reg == mms_pkg::BK_EMIT)
            |-> (mms_pkg::CNT_W'(idx_reg) < job_reg.count))
        else $error("back: chain index beyond loaded set");

    a_depth_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mms_pkg::BK_CHECK) |-> ({1'b0, depth_reg} < 4'(DEPTH_LIMIT)))
        else $error("back: trial beyond depth limit");

    a_fail_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> m_last_reg)
        else $error("back: failure result not marked last");

endmodule

FILE: hw/rtl/merged_mining_slot_assigner_unit.sv
// Merged-mining slot assigner. Chain ids are loaded one per cycle while the
// input is ready; the request marked last starts a search for a collision-free
// placement of the set among the leaves of a chain merkle tree, and the block
// then returns one result per chain in load order (or one failure result). A
// trial checks the chains one at a time, by a single slot hash and bitmap
// lookup each, and ends at the first collision; a search first takes the set
// from the queue. Results then leave at one per cycle while the output is
// ready. Ids live in two banks, so the next set loads while a search runs; the
// input stalls only when a second set is complete before the first has
// delivered its results.
module merged_mining_slot_assigner_unit #(
    parameter int MAX_CHAINS  = mms_pkg::MAX_CHAINS_DEF,
    parameter int DEPTH_LIMIT = mms_pkg::DEPTH_LIMIT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mms_pkg::ID_W-1:0]      s_chain_id,
    input  logic                          s_last_chain,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mms_pkg::NUM_W-1:0]     m_chain_number,
    output logic [mms_pkg::SLOT_W-1:0]    m_chain_slot,
    output logic [mms_pkg::SLOT_W-1:0]    m_search_nonce,
    output logic [mms_pkg::SIZE_W-1:0]    m_tree_size,
    output logic                          m_found,
    output logic                          m_last_result
);

    mms_pkg::id_wr_t id_wr;
    mms_pkg::job_t   push_job;
    mms_pkg::job_t   pop_job;
    logic            job_push;
    logic            job_pop;
    logic            job_empty;
    logic            job_done;

    // loading and classification
    mms_front #(
        .MAX_CHAINS  (MAX_CHAINS),
        .DEPTH_LIMIT (DEPTH_LIMIT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_chain_id   (s_chain_id),
        .s_last_chain (s_last_chain),
        .id_wr        (id_wr),
        .job_push     (job_push),
        .job          (push_job),
        .job_done     (job_done)
    );

    // loaded sets waiting for the search
    mms_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .pop_job  (pop_job),
        .empty    (job_empty)
    );

    // search and results
    mms_back #(
        .MAX_CHAINS  (MAX_CHAINS),
        .DEPTH_LIMIT (DEPTH_LIMIT)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .id_wr          (id_wr),
        .job_empty      (job_empty),
        .job_in         (pop_job),
        .job_pop        (job_pop),
        .job_done       (job_done),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chain_number (m_chain_number),
        .m_chain_slot   (m_chain_slot),
        .m_search_nonce (m_search_nonce),
        .m_tree_size    (m_tree_size),
        .m_found        (m_found),
        .m_last_result  (m_last_result)
    );

endmodule

FILE: tb/slot_placement_checker.sv
`timescale 1ns / 1ps

module slot_placement_checker #(
    parameter int MAX_CHAINS  = mms_pkg::MAX_CHAINS_DEF,
    parameter int DEPTH_LIMIT = mms_pkg::DEPTH_LIMIT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [mms_pkg::ID_W-1:0]   s_chain_id,
    input  logic                       s_last_chain,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [mms_pkg::NUM_W-1:0]  m_chain_number,
    input  logic [mms_pkg::SLOT_W-1:0] m_chain_slot,
    input  logic [mms_pkg::SLOT_W-1:0] m_search_nonce,
    input  logic [mms_pkg::SIZE_W-1:0] m_tree_size,
    input  logic                       m_found,
    input  logic                       m_last_result,
    output int                         mismatches,
    output int                         placements_pending
);

    localparam logic [31:0] HASH_MUL  = 32'd1103515245;
    localparam logic [31:0] HASH_INC  = 32'd12345;
    localparam int          ID_SLOTS  = 64;
    localparam int          MAX_DEPTH = 7;

    typedef struct packed {
        logic [mms_pkg::NUM_W-1:0]  number;
        logic [mms_pkg::SLOT_W-1:0] slot;
        logic [mms_pkg::SLOT_W-1:0] nonce;
        logic [mms_pkg::SIZE_W-1:0] size;
        logic                       found;
        logic                       last;
    } placement_t;

    placement_t                placements_due[$];
    logic [mms_pkg::ID_W-1:0]  loaded_ids[ID_SLOTS];
    int                        loaded_count;

    initial begin
        mismatches         = 0;
        placements_pending = 0;
        loaded_count       = 0;
    end

    // leaf index: double lcg step on nonce and id, low depth bits kept
    function automatic int unsigned leaf_index(input int unsigned nonce,
                                               input logic [mms_pkg::ID_W-1:0] id,
                                               input int depth);
        logic [31:0] r;
        r = nonce * HASH_MUL + HASH_INC;
        r = r + {16'd0, id};
        r = r * HASH_MUL + HASH_INC;
        return r & ((32'd1 << depth) - 32'd1);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // search over depths and nonces for the loaded set, queue the results
    task automatic search_placement();
        logic [mms_pkg::SLOT_W-1:0] slot_of[ID_SLOTS];
        bit                         taken[128];
        int                         n, depth, nonce, i, win_depth, win_nonce;
        int unsigned                s;
        bit                         placed, clash;
        placement_t                 res;
        n            = loaded_count;
        loaded_count = 0;
        depth        = 0;
        while (depth < MAX_DEPTH && (1 << depth) < n)
            depth++;
        placed    = 1'b0;
        win_depth = 0;
        win_nonce = 0;
        while (depth < DEPTH_LIMIT && depth <= MAX_DEPTH && !placed) begin
            nonce = 0;
            while (nonce < (1 << depth) && !placed) begin
                taken = '{default: 1'b0};
                clash = 1'b0;
                for (i = 0; i < n && !clash; i++) begin
                    s = leaf_index(nonce, loaded_ids[i], depth);
                    if (taken[s]) begin
                        clash = 1'b1;
                    end else begin
                        taken[s]   = 1'b1;
                        slot_of[i] = s[mms_pkg::SLOT_W-1:0];
                    end
                end
                if (!clash) begin
                    placed    = 1'b1;
                    win_depth = depth;
                    win_nonce = nonce;
                end else begin
                    nonce++;
                end
            end
            if (!placed)
                depth++;
        end
        if (!placed || n == 0) begin
            res      = '0;
            res.last = 1'b1;
            placements_due.push_back(res);
        end else begin
            for (i = 0; i < n; i++) begin
                res.number = i[mms_pkg::NUM_W-1:0];
                res.slot   = slot_of[i];
                res.nonce  = win_nonce[mms_pkg::SLOT_W-1:0];
                res.size   = mms_pkg::SIZE_W'(1 << win_depth);
                res.found  = 1'b1;
                res.last   = (i == n - 1);
                placements_due.push_back(res);
            end
        end
    endtask

    // compare one delivered result with the oldest outstanding one
    task automatic check_result();
        placement_t want;
        if (placements_due.size() == 0) begin
            report_mismatch("result with none outstanding, chain_number",
                            m_chain_number, -1);
            return;
        end
        want = placements_due.pop_front();
        if (m_chain_number !== want.number)
            report_mismatch("chain_number", m_chain_number, want.number);
        if (m_chain_slot !== want.slot)
            report_mismatch("chain_slot", m_chain_slot, want.slot);
        if (m_search_nonce !== want.nonce)
            report_mismatch("search_nonce", m_search_nonce, want.nonce);
        if (m_tree_size !== want.size)
            report_mismatch("tree_size", m_tree_size, want.size);
        if (m_found !== want.found)
            report_mismatch("found", m_found, want.found);
        if (m_last_result !== want.last)
            report_mismatch("last_result", m_last_result, want.last);
    endtask

    // watch both channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            placements_due.delete();
            loaded_count = 0;
        end else begin
            if (m_valid && m_ready)
                check_result();
            if (s_valid && s_ready) begin
                if (loaded_count < MAX_CHAINS && loaded_count < ID_SLOTS) begin
                    loaded_ids[loaded_count] = s_chain_id;
                    loaded_count++;
                end
                if (s_last_chain)
                    search_placement();
            end
        end
        placements_pending = placements_due.size();
    end

endmodule

FILE: tb/merged_mining_slot_assigner_unit_tb.sv
`timescale 1ns / 1ps

module merged_mining_slot_assigner_unit_tb;

    localparam int PHASE_ITEMS  = 52;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_SET      = 24;

    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic [mms_pkg::ID_W-1:0]   s_chain_id   = '0;
    logic                       s_last_chain = 1'b0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic [mms_pkg::NUM_W-1:0]  m_chain_number;
    logic [mms_pkg::SLOT_W-1:0] m_chain_slot;
    logic [mms_pkg::SLOT_W-1:0] m_search_nonce;
    logic [mms_pkg::SIZE_W-1:0] m_tree_size;
    logic                       m_found;
    logic                       m_last_result;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    bit hold_served    = 1'b0;
    int items_sent     = 0;
    int mismatches;
    int placements_pending;

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    merged_mining_slot_assigner_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_chain_id     (s_chain_id),
        .s_last_chain   (s_last_chain),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chain_number (m_chain_number),
        .m_chain_slot   (m_chain_slot),
        .m_search_nonce (m_search_nonce),
        .m_tree_size    (m_tree_size),
        .m_found        (m_found),
        .m_last_result  (m_last_result)
    );

    slot_placement_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_chain_id         (s_chain_id),
        .s_last_chain       (s_last_chain),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_chain_number     (m_chain_number),
        .m_chain_slot       (m_chain_slot),
        .m_search_nonce     (m_search_nonce),
        .m_tree_size        (m_tree_size),
        .m_found            (m_found),
        .m_last_result      (m_last_result),
        .mismatches         (mismatches),
        .placements_pending (placements_pending)
    );

    // result side: random stalls, one long hold-off on demand
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // offer one request and wait for it to be taken
    task automatic send_request(input logic [mms_pkg::ID_W-1:0] id, input logic last);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_chain_id   <= id;
        s_last_chain <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent++;
    endtask

    // one chain set of random ids, optionally with a forced slot clash
    task automatic send_chain_set(input int n, input bit collide);
        logic [mms_pkg::ID_W-1:0] ids[MAX_SET];
        int                       i, a, b, stored;
        for (i = 0; i < n; i++)
            ids[i] = mms_pkg::ID_W'($urandom);
        stored = (n < mms_pkg::MAX_CHAINS_DEF) ? n : mms_pkg::MAX_CHAINS_DEF;
        // same low seven bits collide at every depth
        if (collide && stored >= 2) begin
            a      = $urandom_range(stored - 2);
            b      = $urandom_range(stored - 1, a + 1);
            ids[b] = {ids[b][mms_pkg::ID_W-1:mms_pkg::SLOT_W],
                      ids[a][mms_pkg::SLOT_W-1:0]};
        end
        for (i = 0; i < n; i++)
            send_request(ids[i], i == n - 1);
    endtask

    task automatic random_sets(input int budget);
        int goal, pick, n;
        goal = items_sent + budget;
        while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 8)
                n = $urandom_range(20, mms_pkg::MAX_CHAINS_DEF + 1);
            else if (pick < 40)
                n = $urandom_range(4, 1);
            else
                n = $urandom_range(mms_pkg::MAX_CHAINS_DEF, 1);
            send_chain_set(n, $urandom_range(99) < 15);
        end
    endtask

    // stimulus and verdict
    initial begin
        int i;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // single chains at both id extremes, then a pair of them
        send_request(16'h0000, 1'b1);
        send_request(16'hFFFF, 1'b1);
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b1);
        // identical ids never place
        send_request(16'h1234, 1'b0);
        send_request(16'h1234, 1'b1);
        // ids sharing the low seven bits never place either
        send_request(16'h0005, 1'b0);
        send_request(16'h8085, 1'b1);
        // overfull set: the marked request is dropped but still starts the search
        for (i = 0; i < mms_pkg::MAX_CHAINS_DEF; i++)
            send_request(mms_pkg::ID_W'($urandom), 1'b0);
        send_request(16'hABCD, 1'b1);

        // no idling, with one long result hold-off so the input backs up
        hold_req = 1'b1;
        for (i = 0; i < 4; i++)
            send_chain_set(3, 1'b0);
        random_sets(PHASE_ITEMS);

        send_idle_pct = 45;
        random_sets(PHASE_ITEMS);

        send_idle_pct  = 0;
        recv_stall_pct = 45;
        random_sets(PHASE_ITEMS);

        send_idle_pct  = 30;
        recv_stall_pct = 30;
        random_sets(PHASE_ITEMS);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (placements_pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatches == 0)
            $display("[merged_mining_slot_assigner_unit] OK");
        else
            $display("[merged_mining_slot_assigner_unit] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("[merged_mining_slot_assigner_unit] ERROR");
        $finish;
    end

endmodule
